### rtl/ris_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ris_pkg: shared types and constants for the resonator impedance sum
// Sequencer states, the saturating add and fixed widths.
// ---------------------------------------------------------------------------
package ris_pkg;

  localparam int unsigned FreqW  = 40;
  localparam int unsigned QW     = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned DivW   = 128;
  localparam int unsigned DivCntW = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_B,
    ST_MUL_Y,
    ST_MUL_D,
    ST_DIV_RE,
    ST_MUL_P,
    ST_DIV_IM,
    ST_ACC,
    ST_OUT
  } state_e;

  // saturating signed add
  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                              input logic [SumW-1:0] b);
    logic [SumW-1:0] s;
    s = a + b;
    if (!a[SumW-1] && !b[SumW-1] && s[SumW-1]) begin
      s = {1'b0, {(SumW-1){1'b1}}};
    end else if (a[SumW-1] && b[SumW-1] && !s[SumW-1]) begin
      s = {1'b1, {(SumW-1){1'b0}}};
    end
    return s;
  endfunction

endpackage

### rtl/ris_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ris_in_if / ris_out_if: valid-ready channels
// Input carries one resonator at one frequency; output the two sums.
// ---------------------------------------------------------------------------
interface ris_in_if;
  logic        valid;
  logic        ready;
  logic [39:0] frequency;
  logic [39:0] resonant_freq;
  logic [31:0] quality;
  logic [31:0] shunt;
  logic        last_resonator;
  modport source (output valid, frequency, resonant_freq, quality, shunt,
                  last_resonator, input ready);
  modport sink (input valid, frequency, resonant_freq, quality, shunt,
                last_resonator, output ready);
endinterface

interface ris_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] real_sum;
  logic [63:0] imag_sum;
  modport source (output valid, real_sum, imag_sum, input ready);
  modport sink (input valid, real_sum, imag_sum, output ready);
endinterface

### rtl/resonator_impedance_sum.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// resonator_impedance_sum: summed impedance of parallel RLC resonators
// Sequencer around a bit-serial divider and a two-bit-a-step multiplier.
// ---------------------------------------------------------------------------
// Usage: in_if carries one beat per resonator at one frequency point; beats
// are summed into signed Q48.16 real and imaginary accumulators with
// saturation. A beat with last_resonator set produces one out_if beat with
// both sums and clears them.
// One item at a time: ready is high only when the sequencer is idle.
// Per item: four divisions on the shared divider and three products on the
// shared multiplier, then ST_ACC. A non-last item makes ready return as the
// sequencer leaves ST_ACC; a last item's result becomes valid at that point.
// A zero frequency or resonant frequency skips the arithmetic, adds nothing
// to the sums and goes straight from ST_DIV_A to ST_ACC.
// The output beat is held in a register until taken; while the receiver
// stalls, no new item is accepted, and ready returns once ST_OUT sees the take.
// Reset clears both accumulators and the sequencer; the output goes invalid.
// ---------------------------------------------------------------------------
module resonator_impedance_sum
  import ris_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ris_in_if.sink    in_if,
  ris_out_if.source out_if
);

  state_e state_q, state_d;
  logic [FreqW-1:0] f_q, fr_q;
  logic [QW-1:0]    qf_q, r_q;
  logic             last_q;
  logic [SumW-1:0]  a_q, m_q, y_q;
  logic             neg_q;
  logic [DivW-1:0]  den_q, num_q;
  logic [SumW-1:0]  re_t_q;
  logic [SumW-1:0]  re_acc_q, im_acc_q;
  logic [SumW-1:0]  out_re_q, out_im_q;
  logic             out_v_q;
  logic             skip;

  logic            div_start, div_done;
  logic [DivW-1:0] div_num, div_den;
  logic [SumW-1:0] div_quot;
  logic            mul_start, mul_done;
  logic [SumW-1:0] mul_a, mul_b;
  logic [DivW-1:0] mul_prod;

  logic [SumW-1:0] b_val, m_val;
  logic            neg_val;
  logic [SumW-1:0] y_sat;
  logic [SumW-1:0] im_term;
  logic            accept, enter;

  assign accept = in_if.valid && in_if.ready;
  assign skip   = (f_q == '0) || (fr_q == '0);

  ris_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  ris_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // ST_IDLE moves on after accept; enter means first cycle in the new state
  logic entered_q;
  assign enter = !entered_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_DIV_A;
      ST_DIV_A:  if (skip) state_d = ST_ACC;
                 else if (div_done) state_d = ST_DIV_B;
      ST_DIV_B:  if (div_done) state_d = ST_MUL_Y;
      ST_MUL_Y:  if (mul_done) state_d = ST_MUL_D;
      ST_MUL_D:  if (mul_done) state_d = ST_DIV_RE;
      ST_DIV_RE: if (div_done) state_d = ST_MUL_P;
      ST_MUL_P:  if (mul_done) state_d = ST_DIV_IM;
      ST_DIV_IM: if (div_done) state_d = ST_ACC;
      ST_ACC:    state_d = last_q ? ST_OUT : ST_IDLE;
      ST_OUT:    if (!out_v_q) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    mul_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_DIV_A: begin
        div_start = enter && !skip;
        div_num = {{(DivW-FreqW-24){1'b0}}, f_q, 24'd0};
        div_den = {{(DivW-FreqW){1'b0}}, fr_q};
      end
      ST_DIV_B: begin
        div_start = enter;
        div_num = {{(DivW-FreqW-24){1'b0}}, fr_q, 24'd0};
        div_den = {{(DivW-FreqW){1'b0}}, f_q};
      end
      ST_MUL_Y: begin
        mul_start = enter;
        mul_a = {{(SumW-QW){1'b0}}, qf_q};
        mul_b = m_q;
      end
      ST_MUL_D: begin
        mul_start = enter;
        mul_a = y_q;
        mul_b = y_q;
      end
      ST_DIV_RE: begin
        div_start = enter;
        div_num = {{(DivW-QW-40){1'b0}}, r_q, 40'd0};
        div_den = den_q;
      end
      ST_MUL_P: begin
        mul_start = enter;
        mul_a = {{(SumW-QW){1'b0}}, r_q};
        mul_b = y_q;
      end
      ST_DIV_IM: begin
        div_start = enter;
        div_num = {num_q[DivW-25:0], 24'd0};
        div_den = den_q;
      end
      default: ;
    endcase
  end

  // magnitude of a - b and the sign of x
  always_comb begin
    b_val   = div_quot;
    neg_val = a_q < b_val;
    m_val   = neg_val ? (b_val - a_q) : (a_q - b_val);
    // Y = floor(Q*m / 2^16), capped at 2^63 - 1
    if (mul_prod[DivW-1:SumW+16-1] != '0) y_sat = {1'b0, {(SumW-1){1'b1}}};
    else y_sat = mul_prod[SumW+16-1:16];
    im_term = neg_q ? div_quot : (~div_quot + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      entered_q <= 1'b0;
      re_acc_q  <= '0;
      im_acc_q  <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      entered_q <= (state_d == state_q);
      if (out_v_q && out_if.ready) out_v_q <= 1'b0;
      if (state_q == ST_DIV_IM && div_done) begin
        re_acc_q <= sat_add(re_acc_q, re_t_q);
        im_acc_q <= sat_add(im_acc_q, im_term);
      end
      if (state_q == ST_ACC && last_q) begin
        out_v_q  <= 1'b1;
        re_acc_q <= '0;
        im_acc_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_q    <= in_if.frequency;
      fr_q   <= in_if.resonant_freq;
      qf_q   <= in_if.quality;
      r_q    <= in_if.shunt;
      last_q <= in_if.last_resonator;
    end
    if (state_q == ST_DIV_A && div_done) a_q <= div_quot;
    if (state_q == ST_DIV_B && div_done) begin
      m_q   <= m_val;
      neg_q <= neg_val;
    end
    if (state_q == ST_MUL_Y && mul_done) y_q <= y_sat;
    if (state_q == ST_MUL_D && mul_done) den_q <= mul_prod + (DivW'(1) << 32);
    if (state_q == ST_DIV_RE && div_done) re_t_q <= div_quot;
    if (state_q == ST_MUL_P && mul_done) num_q <= mul_prod;
    if (state_q == ST_ACC && last_q) begin
      out_re_q <= re_acc_q;
      out_im_q <= im_acc_q;
    end
  end

  assign in_if.ready     = (state_q == ST_IDLE);
  assign out_if.valid    = out_v_q;
  assign out_if.real_sum = out_re_q;
  assign out_if.imag_sum = out_im_q;

endmodule

### rtl/ris_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ris_div: restoring bit-serial divider
// One quotient bit per cycle over a 128 bit numerator; 64 bit quotient.
// ---------------------------------------------------------------------------
module ris_div
  import ris_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DivW-1:0]   num_i,
  input  logic [DivW-1:0]   den_i,
  output logic              done_o,
  output logic [SumW-1:0]   quot_o
);

  logic [DivW-1:0]    num_q, num_d;
  logic [DivW-1:0]    den_q, den_d;
  logic [DivW:0]      rem_q, rem_d;
  logic [SumW-1:0]    quot_q, quot_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DivW:0]      shifted;
  logic [DivW:0]      diff;

  always_comb begin
    shifted = {rem_q[DivW-1:0], num_q[DivW-1]};
    diff    = shifted - {1'b0, den_q};
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[DivW-2:0], 1'b0};
      if (!diff[DivW]) begin
        rem_d  = diff;
        quot_d = {quot_q[SumW-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/ris_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ris_mul: shift-add multiplier, 64 x 64 to 128 bits
// Two multiplier bits per cycle.
// ---------------------------------------------------------------------------
module ris_mul
  import ris_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SumW-1:0]   a_i,
  input  logic [SumW-1:0]   b_i,
  output logic              done_o,
  output logic [DivW-1:0]   prod_o
);

  logic [DivW-1:0] acc_q, acc_d;
  logic [DivW-1:0] a_q, a_d;
  logic [SumW-1:0] b_q, b_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = {{(DivW-SumW){1'b0}}, a_i};
      b_d    = b_i;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + (b_q[0] ? a_q : '0) + (b_q[1] ? {a_q[DivW-2:0], 1'b0} : '0);
      a_d   = {a_q[DivW-3:0], 2'b00};
      b_d   = {2'b00, b_q[SumW-1:2]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### rtl/ris_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ris_checker: port-level checks for the resonator impedance sum
// Watches the two channels only.
// ---------------------------------------------------------------------------
module ris_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_real_i
);

  // an accepted beat is worked on alone
  a_no_back_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after accept");

  // a result only follows a last beat, so no input is taken while it waits
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result stalled");

  // an accepted non-last beat never yields a result next cycle
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i && !out_valid_i |=> !out_valid_i)
    else $error("unexpected result");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_real_i))
    else $error("stalled result changed");

endmodule

bind resonator_impedance_sum ris_checker u_ris_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .in_last_i  (in_if.last_resonator),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_real_i (out_if.real_sum)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for resonator_impedance_sum
// Sends resonator beats grouped per frequency point. A predictor of the
// fixed-point impedance sums builds the expected output beats, and every
// output beat is checked against them in order. Both sides stall at random.
// ---------------------------------------------------------------------------
module testbench;
  import ris_pkg::*;

  localparam logic [127:0] YCap    = 128'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [39:0]  FreqMax = 40'hFF_FFFF_FFFF;
  localparam int unsigned  TailCyc = 1400;

  typedef struct packed {
    logic [39:0] freq;
    logic [39:0] fres;
    logic [31:0] qual;
    logic [31:0] shunt;
    logic        last;
  } reso_t;

  typedef struct packed {
    logic [63:0] re;
    logic [63:0] im;
  } sums_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  ris_in_if  in_if ();
  ris_out_if out_if ();

  resonator_impedance_sum uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #5 clk_i = ~clk_i;

  sums_t       sums_q[$];
  logic [63:0] acc_re, acc_im;
  int unsigned n_errors;
  bit          no_idle;

  function automatic logic [63:0] sat_sum(input logic [63:0] acc, input logic [63:0] v);
    logic signed [64:0] s;
    s = $signed({acc[63], acc}) + $signed({v[63], v});
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // fold one resonator into the running sums; true when a beat is due
  function automatic bit add_resonator(input reso_t it, output sums_t res);
    logic [63:0]  a, b, m, t;
    logic [127:0] y, den, re_q, im_q;
    logic         neg;
    if (it.freq != 0 && it.fres != 0) begin
      a   = {it.freq, 24'b0} / {24'b0, it.fres};
      b   = {it.fres, 24'b0} / {24'b0, it.freq};
      neg = a < b;
      m   = neg ? b - a : a - b;
      y   = ({64'b0, m} * {96'b0, it.qual}) >> 16;
      if (y > YCap) y = YCap;
      den  = y * y + (128'd1 << 32);
      re_q = ({96'b0, it.shunt} << 40) / den;
      im_q = (({96'b0, it.shunt} * y) << 24) / den;
      acc_re = sat_sum(acc_re, re_q[63:0]);
      t = neg ? im_q[63:0] : -im_q[63:0];
      acc_im = sat_sum(acc_im, t);
    end
    res.re = acc_re;
    res.im = acc_im;
    if (it.last) begin
      acc_re = '0;
      acc_im = '0;
    end
    return it.last;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    n_errors++;
  endtask

  // one beat on the input channel; valid stays high across back-to-back beats
  task automatic send_beat(input reso_t it);
    int unsigned gap;
    sums_t       res;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.frequency      <= it.freq;
    in_if.resonant_freq  <= it.fres;
    in_if.quality        <= it.qual;
    in_if.shunt          <= it.shunt;
    in_if.last_resonator <= it.last;
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    if (add_resonator(it, res)) sums_q.push_back(res);
  endtask

  function automatic logic [39:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[39:0];
  endfunction

  function automatic reso_t rand_reso(input bit last);
    reso_t it;
    it.fres = rand40() >> $urandom_range(0, 39);
    if (it.fres == 0) it.fres = 40'd1;
    case ($urandom_range(0, 5))
      0:       it.freq = 40'd0;
      1, 2:    it.freq = it.fres + 40'($urandom_range(0, 2000)) - 40'd1000;
      3:       it.freq = rand40() >> $urandom_range(0, 39);
      default: it.freq = rand40();
    endcase
    it.qual  = $urandom >> $urandom_range(0, 31);
    it.shunt = $urandom >> $urandom_range(0, 31);
    it.last  = last;
    return it;
  endfunction

  task automatic test_directed();
    // on resonance, extremes, zero frequency, zero resonant freq, huge Q*x
    send_beat('{40'd1000, 40'd1000, 32'd256, 32'd256, 1'b1});
    send_beat('{FreqMax, FreqMax, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    send_beat('{40'd0, 40'd1000, 32'd256, 32'd256, 1'b0});
    send_beat('{40'd0, 40'd1000, 32'd256, 32'd256, 1'b1});
    send_beat('{40'd500, 40'd0, 32'd256, 32'd256, 1'b1});
    send_beat('{40'd1, FreqMax, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    send_beat('{FreqMax, 40'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    send_beat('{FreqMax, 40'd1, 32'd1, 32'hFFFF_FFFF, 1'b1});
    send_beat('{40'd999, 40'd1000, 32'd25600, 32'd2560, 1'b0});
    send_beat('{40'd1001, 40'd1000, 32'd25600, 32'd2560, 1'b0});
    send_beat('{40'd1000, 40'd1000, 32'd0, 32'hFFFF_FFFF, 1'b1});
    send_beat('{40'd123456, 40'd654321, 32'd0, 32'd0, 1'b1});
    send_beat('{40'hAA_AAAA_AAAA, 40'h55_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1});
    send_beat('{40'h55_5555_5555, 40'hAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1});
    repeat (6) send_beat('{FreqMax, FreqMax, 32'd1, 32'hFFFF_FFFF, 1'b0});
    send_beat('{FreqMax, FreqMax, 32'd1, 32'hFFFF_FFFF, 1'b1});
  endtask

  // frequency points of 1 to 6 resonators, with some stray beats as noise
  task automatic test_random_points(input int unsigned n_beats);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(rand_reso($urandom_range(0, 1) == 1));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++) send_beat(rand_reso(i == len - 1));
        sent += len;
      end
    end
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    test_random_points(120);
    no_idle = 1'b0;
  endtask

  // output side: random stall before each beat, check at the falling edge
  initial begin
    int unsigned stall;
    sums_t       exp_s;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(negedge clk_i);
      while (!(out_if.valid && out_if.ready)) @(negedge clk_i);
      if (sums_q.size() == 0) begin
        report("unexpected beat", out_if.real_sum, '0);
      end else begin
        exp_s = sums_q.pop_front();
        if (out_if.real_sum !== exp_s.re) report("real_sum", out_if.real_sum, exp_s.re);
        if (out_if.imag_sum !== exp_s.im) report("imag_sum", out_if.imag_sum, exp_s.im);
      end
      @(posedge clk_i);
    end
  end

  initial begin
    n_errors = 0;
    no_idle  = 1'b0;
    acc_re   = '0;
    acc_im   = '0;
    in_if.valid          <= 1'b0;
    in_if.frequency      <= '0;
    in_if.resonant_freq  <= '0;
    in_if.quality        <= '0;
    in_if.shunt          <= '0;
    in_if.last_resonator <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_points(400);
    test_no_idle();
    test_random_points(400);
    in_if.valid <= 1'b0;
    while (sums_q.size() != 0) @(posedge clk_i);
    repeat (TailCyc) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
rtl/ris_pkg.sv
rtl/ris_if.sv
rtl/ris_div.sv
rtl/ris_mul.sv
rtl/resonator_impedance_sum.sv
rtl/ris_checker.sv
bench/testbench.sv
